// ===== sv/lbfb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lbfb_pkg;

    localparam int LBFB_QUEUE_DEPTH = 2;
    localparam int CHUNK_BYTES = 16;
    localparam int GLYPH_BYTES = 11;
    localparam int CHUNK_W = 8 * CHUNK_BYTES;
    localparam int GLYPH_W = 8 * GLYPH_BYTES;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_INDEX_W = 3;

    localparam logic [7:0] FIRST_GLYPH = 8'h20;
    localparam logic [7:0] LAST_GLYPH = 8'h7E;
    localparam logic [3:0] MODE_MAX = 4'd8;
    localparam logic [47:0] MAGIC = 48'h77616E670000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FLASH     = 3'd0,
        REG_MARQUEE   = 3'd1,
        REG_SPEED     = 3'd2,
        REG_MODE      = 3'd3,
        REG_GLYPHS    = 3'd4,
        REG_TIMESTAMP = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic        flash;
        logic        marquee;
        logic [2:0]  speed;
        logic [3:0]  mode;
        logic [15:0] glyph_count;
        logic [47:0] timestamp;
    } cfg_t;

    // one classified character
    typedef struct packed {
        logic       hdr;
        logic       glyph_ok;
        logic [6:0] glyph_idx;
        logic       last;
    } cmd_t;

    function automatic logic [GLYPH_W-1:0] font_glyph(input logic [6:0] idx);
        logic [GLYPH_W-1:0] g;
        case (idx)
            7'd0:  g = 88'h0000000000000000000000;
            7'd1:  g = 88'h00183C3C3C181800181800;
            7'd2:  g = 88'h6666222200000000000000;
            7'd3:  g = 88'h006C6CFE6C6CFE6C6C0000;
            7'd4:  g = 88'h107CD6D6701CD6D67C1010;
            7'd5:  g = 88'h006092966C106CD2920C00;
            7'd6:  g = 88'h00386C6C3876DCCCCC7600;
            7'd7:  g = 88'h1818081000000000000000;
            7'd8:  g = 88'h000C183030303030180C00;
            7'd9:  g = 88'h0030180C0C0C0C0C183000;
            7'd10: g = 88'h000000663CFF3C66000000;
            7'd11: g = 88'h00000018187E1818000000;
            7'd12: g = 88'h0000000000000030301020;
            7'd13: g = 88'h0000000000FE0000000000;
            7'd14: g = 88'h0000000000000000303000;
            7'd15: g = 88'h000002060C183060C08000;
            7'd16: g = 88'h007CC6CEDEF6E6C6C67C00;
            7'd17: g = 88'h0018387818181818187E00;
            7'd18: g = 88'h007CC6060C183060C6FE00;
            7'd19: g = 88'h007CC606063C0606C67C00;
            7'd20: g = 88'h000C1C3C6CCCFE0C0C1E00;
            7'd21: g = 88'h00FEC0C0FC060606C67C00;
            7'd22: g = 88'h007CC6C0C0FCC6C6C67C00;
            7'd23: g = 88'h00FEC6060C183030303000;
            7'd24: g = 88'h007CC6C6C67CC6C6C67C00;
            7'd25: g = 88'h007CC6C6C67E0606C67C00;
            7'd26: g = 88'h0000001818000018180000;
            7'd27: g = 88'h0000001818000018180810;
            7'd28: g = 88'h00060C18306030180C0600;
            7'd29: g = 88'h0000007E00007E00000000;
            7'd30: g = 88'h006030180C060C18306000;
            7'd31: g = 88'h007CC6C60C181800181800;
            7'd32: g = 88'h00003C429DA5ADB6403C00;
            7'd33: g = 88'h00386CC6C6FEC6C6C6C600;
            7'd34: g = 88'h00FC6666667C666666FC00;
            7'd35: g = 88'h007CC6C6C0C0C0C6C67C00;
            7'd36: g = 88'h00FC66666666666666FC00;
            7'd37: g = 88'h00FE66626878686266FE00;
            7'd38: g = 88'h00FE66626878686060F000;
            7'd39: g = 88'h007CC6C6C0C0CEC6C67E00;
            7'd40: g = 88'h00C6C6C6C6FEC6C6C6C600;
            7'd41: g = 88'h003C181818181818183C00;
            7'd42: g = 88'h001E0C0C0C0C0CCCCC7800;
            7'd43: g = 88'h00E6666C6C786C6C66E600;
            7'd44: g = 88'h00F060606060606266FE00;
            7'd45: g = 88'h0082C6EEFED6C6C6C6C600;
            7'd46: g = 88'h0086C6E6F6DECEC6C6C600;
            7'd47: g = 88'h007CC6C6C6C6C6C6C67C00;
            7'd48: g = 88'h00FC6666667C606060F000;
            7'd49: g = 88'h007CC6C6C6C6C6D6DE7C06;
            7'd50: g = 88'h00FC6666667C6C6666E600;
            7'd51: g = 88'h007CC6C660380CC6C67C00;
            7'd52: g = 88'h007E7E5A18181818183C00;
            7'd53: g = 88'h00C6C6C6C6C6C6C6C67C00;
            7'd54: g = 88'h00C6C6C6C6C6C66C381000;
            7'd55: g = 88'h00C6C6C6C6D6FEEEC68200;
            7'd56: g = 88'h00C6C66C7C387C6CC6C600;
            7'd57: g = 88'h00666666663C1818183C00;
            7'd58: g = 88'h00FEC6860C183062C6FE00;
            7'd59: g = 88'h003C303030303030303C00;
            7'd60: g = 88'h0080C06030180C06020000;
            7'd61: g = 88'h003C0C0C0C0C0C0C0C3C00;
            7'd62: g = 88'h386CC60000000000000000;
            7'd63: g = 88'h00000000000000000000FF;
            7'd64: g = 88'h1818100800000000000000;
            7'd65: g = 88'h00000000780C7CCCCC7600;
            7'd66: g = 88'h00E060607C666666667C00;
            7'd67: g = 88'h000000007CC6C0C0C67C00;
            7'd68: g = 88'h001C0C0C7CCCCCCCCC7600;
            7'd69: g = 88'h000000007CC6FEC0C67C00;
            7'd70: g = 88'h001C363078303030307800;
            7'd71: g = 88'h00000076CCCCCC7C0CCC78;
            7'd72: g = 88'h00E060606C76666666E600;
            7'd73: g = 88'h0018180038181818183C00;
            7'd74: g = 88'h0C0C001C0C0C0C0CCCCC78;
            7'd75: g = 88'h00E06060666C78786CE600;
            7'd76: g = 88'h0038181818181818183C00;
            7'd77: g = 88'h00000000ECFED6D6D6C600;
            7'd78: g = 88'h00000000DC666666666600;
            7'd79: g = 88'h000000007CC6C6C6C67C00;
            7'd80: g = 88'h000000DC6666667C6060F0;
            7'd81: g = 88'h0000007CCCCCCC7C0C0C1E;
            7'd82: g = 88'h00000000DE76606060F000;
            7'd83: g = 88'h000000007CC6701CC67C00;
            7'd84: g = 88'h00103030FC303030341800;
            7'd85: g = 88'h00000000CCCCCCCCCC7600;
            7'd86: g = 88'h00000000C6C6C66C381000;
            7'd87: g = 88'h00000000C6D6D6D6FE6C00;
            7'd88: g = 88'h00000000C66C38386CC600;
            7'd89: g = 88'h000000C6C6C6C67E060CF8;
            7'd90: g = 88'h00000000FE8C183062FE00;
            7'd91: g = 88'h000E181818701818180E00;
            7'd92: g = 88'h0018181818001818181800;
            7'd93: g = 88'h00701818180E1818187000;
            7'd94: g = 88'h0076DC0000000000000000;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== sv/lbfb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lbfb_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    char_code,
    input  wire logic          end_of_text,
    input  wire logic          q_full,
    output logic               push,
    output lbfb_pkg::cmd_t     push_cmd
);
    import lbfb_pkg::*;

    logic in_message_reg;
    logic in_message_next;
    logic [7:0] rel_code;

    assign in_stall = q_full;
    assign push = in_valid && !q_full;
    assign rel_code = char_code - FIRST_GLYPH;

    always_comb
    begin
        push_cmd.hdr = !in_message_reg;
        push_cmd.glyph_ok = (char_code >= FIRST_GLYPH) && (char_code <= LAST_GLYPH);
        push_cmd.glyph_idx = rel_code[6:0];
        push_cmd.last = end_of_text;
        in_message_next = in_message_reg;
        if (push)
        begin
            in_message_next = !end_of_text;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_message_reg <= 1'b0;
        end
        else
        begin
            in_message_reg <= in_message_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lbfb_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lbfb_queue #(
    parameter int DEPTH = lbfb_pkg::LBFB_QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire lbfb_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output lbfb_pkg::cmd_t     head,
    output logic               empty,
    output logic               full
);
    import lbfb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full = (count_reg == CW'(DEPTH));
    assign head = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lbfb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lbfb_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire lbfb_pkg::cfg_t cfg,
    input  wire lbfb_pkg::cmd_t q_head,
    input  wire logic          q_empty,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [63:0]        chunk_upper,
    output logic [63:0]        chunk_lower,
    output logic               final_chunk
);
    import lbfb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_HDR   = 4'b0010,
        S_GLYPH = 4'b0100,
        S_PAD   = 4'b1000
    } state_t;

    localparam int WIN_W = CHUNK_W + GLYPH_W;
    localparam logic [3:0] SPILL = 4'(CHUNK_BYTES - GLYPH_BYTES);

    state_t state_reg, state_next;
    logic [1:0] hdr_cnt_reg, hdr_cnt_next;
    cmd_t cmd_reg, cmd_next;
    logic [CHUNK_W-1:0] buf_reg, buf_next;
    logic [3:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    logic final_reg, final_next;

    logic out_free;
    logic emit;
    logic done;
    logic spill;
    logic [WIN_W-1:0] win;

    function automatic state_t first_state(input cmd_t c);
        state_t s;
        if (c.hdr)
            s = S_HDR;
        else if (c.glyph_ok)
            s = S_GLYPH;
        else if (c.last)
            s = S_PAD;
        else
            s = S_IDLE;
        return s;
    endfunction

    function automatic logic [CHUNK_W-1:0] hdr_chunk(input logic [1:0] idx, input cfg_t c);
        logic [CHUNK_W-1:0] ch;
        logic [3:0] mode;
        mode = (c.mode > MODE_MAX) ? MODE_MAX : c.mode;
        case (idx)
            2'd0: ch = {MAGIC, 7'b0, c.flash, 7'b0, c.marquee, 1'b0, c.speed, mode, 56'b0};
            2'd1: ch = {c.glyph_count, 112'b0};
            2'd2: ch = {48'b0, c.timestamp, 32'b0};
            default: ch = '0;
        endcase
        return ch;
    endfunction

    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign chunk_upper = chunk_reg[CHUNK_W-1 -: 64];
    assign chunk_lower = chunk_reg[63:0];
    assign final_chunk = final_reg;

    // pending bytes are kept zero past the count, so the glyph can be ORed in
    assign win = {buf_reg, {GLYPH_W{1'b0}}}
               | ({font_glyph(cmd_reg.glyph_idx), {CHUNK_W{1'b0}}} >> {cnt_reg, 3'b000});
    assign spill = (cnt_reg >= SPILL);

    always_comb
    begin
        state_next = state_reg;
        hdr_cnt_next = hdr_cnt_reg;
        cmd_next = cmd_reg;
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        emit = 1'b0;
        done = 1'b0;
        pop = 1'b0;
        chunk_next = chunk_reg;
        final_next = final_reg;

        case (state_reg)
            S_IDLE:
            begin
                done = 1'b1;
            end
            S_HDR:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    chunk_next = hdr_chunk(hdr_cnt_reg, cfg);
                    final_next = 1'b0;
                    hdr_cnt_next = hdr_cnt_reg + 1'b1;
                    if (hdr_cnt_reg == 2'd3)
                    begin
                        buf_next = '0;
                        cnt_next = '0;
                        if (cmd_reg.glyph_ok)
                            state_next = S_GLYPH;
                        else if (cmd_reg.last)
                            state_next = S_PAD;
                        else
                            done = 1'b1;
                    end
                end
            end
            S_GLYPH:
            begin
                if (!spill || out_free)
                begin
                    if (spill)
                    begin
                        emit = 1'b1;
                        chunk_next = win[WIN_W-1 -: CHUNK_W];
                        final_next = 1'b0;
                        buf_next = {win[GLYPH_W-1:0], {(CHUNK_W - GLYPH_W){1'b0}}};
                        cnt_next = cnt_reg - SPILL;
                    end
                    else
                    begin
                        buf_next = win[WIN_W-1 -: CHUNK_W];
                        cnt_next = cnt_reg + 4'(GLYPH_BYTES);
                    end
                    if (cmd_reg.last)
                        state_next = S_PAD;
                    else
                        done = 1'b1;
                end
            end
            S_PAD:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    chunk_next = buf_reg;
                    final_next = 1'b1;
                    buf_next = '0;
                    cnt_next = '0;
                    done = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done)
        begin
            if (!q_empty)
            begin
                pop = 1'b1;
                cmd_next = q_head;
                hdr_cnt_next = '0;
                state_next = first_state(q_head);
            end
            else
            begin
                state_next = S_IDLE;
            end
        end

        if (emit)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        buf_reg <= buf_next;
        chunk_reg <= chunk_next;
        final_reg <= final_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hdr_cnt_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hdr_cnt_reg <= hdr_cnt_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/led_badge_frame_builder_unit.sv =====
// Path: an accepted character is written to the command queue, then popped into the chunk
//   sequencer, whose chunks are registered in the output; the sequencer emits at most one
//   chunk per cycle while the output is not stalled, with four header chunks at each message start.
// The input takes a character every cycle until the command queue fills.
// Reset: registers read zero, no message open, queue and output empty; the pending
//   chunk buffer is not cleared, every message header overwrites it.
`timescale 1ns / 1ps
`default_nettype none

module led_badge_frame_builder_unit #(
    parameter int QUEUE_DEPTH = lbfb_pkg::LBFB_QUEUE_DEPTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               wr_en,
    input  wire logic [lbfb_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  wire logic [lbfb_pkg::CFG_DATA_W-1:0]    wr_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [7:0]                         char_code,
    input  wire logic                               end_of_text,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [63:0]                             chunk_upper,
    output logic [63:0]                             chunk_lower,
    output logic                                    final_chunk
);
    import lbfb_pkg::*;

    cfg_t cfg_reg;
    cmd_t push_cmd;
    cmd_t q_head;
    logic push;
    logic pop;
    logic q_empty;
    logic q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_FLASH:     cfg_reg.flash <= wr_data[0];
                REG_MARQUEE:   cfg_reg.marquee <= wr_data[0];
                REG_SPEED:     cfg_reg.speed <= wr_data[2:0];
                REG_MODE:      cfg_reg.mode <= wr_data[3:0];
                REG_GLYPHS:    cfg_reg.glyph_count <= wr_data[15:0];
                REG_TIMESTAMP: cfg_reg.timestamp <= wr_data;
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    lbfb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    lbfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    lbfb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_head      (q_head),
        .q_empty     (q_empty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .chunk_upper (chunk_upper),
        .chunk_lower (chunk_lower),
        .final_chunk (final_chunk)
    );

endmodule

`default_nettype wire

// ===== bench/led_badge_frame_builder_unit_test.sv =====
`timescale 1ns / 1ps

module led_badge_frame_builder_unit_test;

    import lbfb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD = 400;
    localparam int PHASE_ITEMS = 34;

    // 95 glyphs of 11 column bytes, glyph for 0x20 in the top bits
    localparam logic [95*88-1:0] FONT_ROM = {
        88'h0000000000000000000000, 88'h00183C3C3C181800181800, 88'h6666222200000000000000,
        88'h006C6CFE6C6CFE6C6C0000, 88'h107CD6D6701CD6D67C1010, 88'h006092966C106CD2920C00,
        88'h00386C6C3876DCCCCC7600, 88'h1818081000000000000000, 88'h000C183030303030180C00,
        88'h0030180C0C0C0C0C183000, 88'h000000663CFF3C66000000, 88'h00000018187E1818000000,
        88'h0000000000000030301020, 88'h0000000000FE0000000000, 88'h0000000000000000303000,
        88'h000002060C183060C08000,
        88'h007CC6CEDEF6E6C6C67C00, 88'h0018387818181818187E00, 88'h007CC6060C183060C6FE00,
        88'h007CC606063C0606C67C00, 88'h000C1C3C6CCCFE0C0C1E00, 88'h00FEC0C0FC060606C67C00,
        88'h007CC6C0C0FCC6C6C67C00, 88'h00FEC6060C183030303000, 88'h007CC6C6C67CC6C6C67C00,
        88'h007CC6C6C67E0606C67C00,
        88'h0000001818000018180000, 88'h0000001818000018180810, 88'h00060C18306030180C0600,
        88'h0000007E00007E00000000, 88'h006030180C060C18306000, 88'h007CC6C60C181800181800,
        88'h00003C429DA5ADB6403C00,
        88'h00386CC6C6FEC6C6C6C600, 88'h00FC6666667C666666FC00, 88'h007CC6C6C0C0C0C6C67C00,
        88'h00FC66666666666666FC00, 88'h00FE66626878686266FE00, 88'h00FE66626878686060F000,
        88'h007CC6C6C0C0CEC6C67E00, 88'h00C6C6C6C6FEC6C6C6C600, 88'h003C181818181818183C00,
        88'h001E0C0C0C0C0CCCCC7800, 88'h00E6666C6C786C6C66E600, 88'h00F060606060606266FE00,
        88'h0082C6EEFED6C6C6C6C600, 88'h0086C6E6F6DECEC6C6C600, 88'h007CC6C6C6C6C6C6C67C00,
        88'h00FC6666667C606060F000, 88'h007CC6C6C6C6C6D6DE7C06, 88'h00FC6666667C6C6666E600,
        88'h007CC6C660380CC6C67C00, 88'h007E7E5A18181818183C00, 88'h00C6C6C6C6C6C6C6C67C00,
        88'h00C6C6C6C6C6C66C381000, 88'h00C6C6C6C6D6FEEEC68200, 88'h00C6C66C7C387C6CC6C600,
        88'h00666666663C1818183C00, 88'h00FEC6860C183062C6FE00,
        88'h003C303030303030303C00, 88'h0080C06030180C06020000, 88'h003C0C0C0C0C0C0C0C3C00,
        88'h386CC60000000000000000, 88'h00000000000000000000FF, 88'h1818100800000000000000,
        88'h00000000780C7CCCCC7600, 88'h00E060607C666666667C00, 88'h000000007CC6C0C0C67C00,
        88'h001C0C0C7CCCCCCCCC7600, 88'h000000007CC6FEC0C67C00, 88'h001C363078303030307800,
        88'h00000076CCCCCC7C0CCC78, 88'h00E060606C76666666E600, 88'h0018180038181818183C00,
        88'h0C0C001C0C0C0C0CCCCC78, 88'h00E06060666C78786CE600, 88'h0038181818181818183C00,
        88'h00000000ECFED6D6D6C600, 88'h00000000DC666666666600, 88'h000000007CC6C6C6C67C00,
        88'h000000DC6666667C6060F0, 88'h0000007CCCCCCC7C0C0C1E, 88'h00000000DE76606060F000,
        88'h000000007CC6701CC67C00, 88'h00103030FC303030341800, 88'h00000000CCCCCCCCCC7600,
        88'h00000000C6C6C66C381000, 88'h00000000C6D6D6D6FE6C00, 88'h00000000C66C38386CC600,
        88'h000000C6C6C6C67E060CF8, 88'h00000000FE8C183062FE00,
        88'h000E181818701818180E00, 88'h0018181818001818181800, 88'h00701818180E1818187000,
        88'h0076DC0000000000000000
    };

    typedef struct {
        logic [7:0] code;
        logic       eot;
    } char_item_t;

    typedef struct {
        logic [63:0] upper;
        logic [63:0] lower;
        logic        last;
    } chunk_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] char_code = '0;
    logic end_of_text = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [63:0] chunk_upper;
    logic [63:0] chunk_lower;
    logic final_chunk;

    led_badge_frame_builder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .chunk_upper (chunk_upper),
        .chunk_lower (chunk_lower),
        .final_chunk (final_chunk)
    );

    always #4 clk = ~clk;

    char_item_t char_q[$];
    chunk_t chunk_q[$];

    // shadow of the framer
    cfg_t shadow_cfg = '0;
    logic [7:0] pend_bytes [16];
    int pend_n = 0;
    bit msg_open = 1'b0;

    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int tx_gap = 0;
    int rx_gap = 0;
    int idle_cycles = 0;
    int n_errors = 0;
    int n_chars = 0;
    int n_messages = 0;
    int n_chunks = 0;
    int n_settings = 1;
    chunk_t want;

    function automatic int draw_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic add_byte(input logic [7:0] b);
        chunk_t c;
        int i;
        pend_bytes[pend_n] = b;
        pend_n++;
        if (pend_n == CHUNK_BYTES) begin
            c.upper = '0;
            c.lower = '0;
            for (i = 0; i < 8; i++) begin
                c.upper = {c.upper[55:0], pend_bytes[i]};
                c.lower = {c.lower[55:0], pend_bytes[8 + i]};
            end
            c.last = 1'b0;
            chunk_q.push_back(c);
            pend_n = 0;
        end
    endtask

    task automatic add_zeros(input int n);
        repeat (n) add_byte(8'h00);
    endtask

    task automatic add_header();
        logic [3:0] mode_sat;
        int k;
        mode_sat = (shadow_cfg.mode > MODE_MAX) ? MODE_MAX : shadow_cfg.mode;
        for (k = 5; k >= 0; k--)
            add_byte(MAGIC[8*k +: 8]);
        add_byte({7'b0, shadow_cfg.flash});
        add_byte({7'b0, shadow_cfg.marquee});
        add_byte({1'b0, shadow_cfg.speed, mode_sat});
        add_zeros(7);
        add_byte(shadow_cfg.glyph_count[15:8]);
        add_byte(shadow_cfg.glyph_count[7:0]);
        add_zeros(20);
        for (k = 5; k >= 0; k--)
            add_byte(shadow_cfg.timestamp[8*k +: 8]);
        add_zeros(20);
    endtask

    task automatic predict_char(input logic [7:0] code, input logic eot);
        logic [87:0] cols;
        int base;
        int k;
        if (!msg_open) begin
            pend_n = 0;
            add_header();
            msg_open = 1'b1;
        end
        if (code >= FIRST_GLYPH && code <= LAST_GLYPH) begin
            base = (94 - (int'(code) - 32)) * 88;
            cols = FONT_ROM[base +: 88];
            for (k = 10; k >= 0; k--)
                add_byte(cols[8*k +: 8]);
        end
        if (eot) begin
            // aligned tail still gets a whole zero chunk
            add_zeros(pend_n == 0 ? CHUNK_BYTES : CHUNK_BYTES - pend_n);
            chunk_q[chunk_q.size() - 1].last = 1'b1;
            msg_open = 1'b0;
            pend_n = 0;
        end
    endtask

    task automatic note_error(input string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            tx_gap = 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                predict_char(char_code, end_of_text);
                n_chars++;
                if (end_of_text)
                    n_messages++;
            end
            if (!in_valid || !in_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (char_q.size() > 0) begin
                    in_valid <= 1'b1;
                    char_code <= char_q[0].code;
                    end_of_text <= char_q[0].eot;
                    void'(char_q.pop_front());
                    tx_gap = draw_gap();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_gap = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                n_chunks++;
                if (chunk_q.size() == 0) begin
                    note_error($sformatf("unexpected chunk %h_%h final=%b",
                        chunk_upper, chunk_lower, final_chunk));
                end
                else begin
                    want = chunk_q.pop_front();
                    if (chunk_upper !== want.upper || chunk_lower !== want.lower
                        || final_chunk !== want.last)
                        note_error($sformatf("chunk exp %h_%h final=%b got %h_%h final=%b",
                            want.upper, want.lower, want.last,
                            chunk_upper, chunk_lower, final_chunk));
                end
            end
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (rx_gap > 0) begin
                rx_gap--;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= 1'b0;
                rx_gap = draw_gap();
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_item(input logic [7:0] code, input logic eot);
        char_item_t it;
        it.code = code;
        it.eot = eot;
        char_q.push_back(it);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_FLASH:     shadow_cfg.flash = val[0];
            REG_MARQUEE:   shadow_cfg.marquee = val[0];
            REG_SPEED:     shadow_cfg.speed = val[2:0];
            REG_MODE:      shadow_cfg.mode = val[3:0];
            REG_GLYPHS:    shadow_cfg.glyph_count = val[15:0];
            REG_TIMESTAMP: shadow_cfg.timestamp = val[47:0];
            default: ;
        endcase
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] flash, input logic [CFG_DATA_W-1:0] marq,
                             input logic [CFG_DATA_W-1:0] speed, input logic [CFG_DATA_W-1:0] mode,
                             input logic [CFG_DATA_W-1:0] glyphs,
                             input logic [CFG_DATA_W-1:0] stamp);
        write_reg(REG_FLASH, flash);
        write_reg(REG_MARQUEE, marq);
        write_reg(REG_SPEED, speed);
        write_reg(REG_MODE, mode);
        write_reg(REG_GLYPHS, glyphs);
        write_reg(REG_TIMESTAMP, stamp);
        @(negedge clk);
        n_settings++;
    endtask

    task automatic wait_drained();
        while (char_q.size() != 0 || in_valid || chunk_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // messages of random text; a few are pure noise
    task automatic queue_messages(input int target);
        int counted;
        int len;
        int j;
        bit noise;
        logic [7:0] code;
        counted = 0;
        while (counted < target) begin
            len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 20);
            noise = ($urandom_range(0, 99) < 8);
            for (j = 0; j < len; j++) begin
                if (noise)
                    code = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 31))
                                                      : 8'($urandom_range(127, 255));
                else if ($urandom_range(0, 99) < 85)
                    code = 8'($urandom_range(32, 126));
                else
                    code = 8'($urandom_range(0, 255));
                add_item(code, j == len - 1);
                if (j == 0 || j == len - 1 || (code >= FIRST_GLYPH && code <= LAST_GLYPH))
                    counted++;
            end
        end
    endtask

    initial begin
        int i;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: header then glyphs at both ends of the font
        add_item(8'h20, 1'b0);
        add_item(8'h7E, 1'b1);
        add_item(8'h41, 1'b1);
        // no glyph at all: header is aligned, so a whole zero chunk follows
        add_item(8'h00, 1'b1);
        add_item(8'hFF, 1'b0);
        add_item(8'h7F, 1'b0);
        add_item(8'h1F, 1'b0);
        add_item(8'h80, 1'b1);
        // 16 glyphs end exactly on a chunk boundary
        for (i = 0; i < 16; i++)
            add_item(8'h21 + 8'(i * 5), i == 15);
        wait_drained();

        write_all(48'd1, 48'd1, 48'd7, 48'd8, 48'hFFFF, 48'hFFFF_FFFF_FFFF);
        queue_messages(PHASE_ITEMS);
        wait_drained();

        // upper bits are dropped; mode 15 saturates
        write_all({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}});
        queue_messages(PHASE_ITEMS);
        hold_req = 1'b1;
        wait_drained();

        calm = 1'b1;
        write_all(48'd0, 48'd0, 48'd0, 48'd9, 48'd0, 48'd0);
        queue_messages(PHASE_ITEMS);
        wait_drained();
        calm = 1'b0;

        repeat (3) begin
            write_all(48'($urandom_range(0, 1)), 48'($urandom_range(0, 1)),
                      48'($urandom_range(0, 7)), 48'($urandom_range(0, 15)),
                      48'($urandom_range(0, 65535)), 48'({$urandom, $urandom}));
            queue_messages(PHASE_ITEMS);
            wait_drained();
        end

        $display("Sent %0d characters in %0d messages under %0d register settings;",
            n_chars, n_messages, n_settings);
        $display("checked %0d chunks with receiver stalls and one long back-pressure hold.",
            n_chunks);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lbfb_pkg.sv
sv/lbfb_front.sv
sv/lbfb_queue.sv
sv/lbfb_back.sv
sv/led_badge_frame_builder_unit.sv
bench/led_badge_frame_builder_unit_test.sv
